// ===== hdl/assert_macros.svh =====
// Assertion macros used by the checker file.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked at every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error("assertion failed");
// Next-cycle implication checked at every rising clock edge outside reset.
`define ASSERT_NEXT(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error("assertion failed");
`endif

// ===== hdl/rbst_pkg.sv =====
// Package for the ray/box slab test: payload structs and fixed widths.
// No dependencies.
package rbst_pkg;
   localparam int CW = 32;
   typedef struct packed {
      logic signed [CW-1:0] origin_x;
      logic signed [CW-1:0] origin_y;
      logic signed [CW-1:0] origin_z;
      logic signed [CW-1:0] dir_x;
      logic signed [CW-1:0] dir_y;
      logic signed [CW-1:0] dir_z;
      logic signed [CW-1:0] box_min_x;
      logic signed [CW-1:0] box_min_y;
      logic signed [CW-1:0] box_min_z;
      logic signed [CW-1:0] box_max_x;
      logic signed [CW-1:0] box_max_y;
      logic signed [CW-1:0] box_max_z;
   } req_type;
   typedef struct packed {
      logic                 hit;
      logic signed [CW-1:0] t_enter;
      logic signed [CW-1:0] t_exit;
   } rsp_type;
endpackage

// ===== hdl/rbst_div.sv =====
// Pipelined restoring fixed-point divider, one quotient bit per stage.
// Depends on nothing; stalls through a shared advance enable.
module rbst_div #(
   parameter int CW = 32,
   parameter int FB = 16
) (
   input  logic          clock,
   input  logic          en,
   input  logic [CW:0]   num_mag,
   input  logic [CW-1:0] den_mag,
   output logic [CW:0]   quo
);
   localparam int NB = CW + 1 + FB;
   logic [NB-1:0] rem_ff [0:NB];
   logic [NB-1:0] q_ff   [0:NB];
   logic [CW-1:0] d_ff   [0:NB];
   logic [NB-1:0] rem_in [0:NB-1];
   logic [NB-1:0] q_in   [0:NB-1];

   // Stage k decides quotient bit NB-1-k; remainder bits are fed from a
   // dividend held left aligned in q_ff until consumed.
   always_comb begin
      for (int k = 0; k < NB; k++) begin
         logic [NB:0] trial;
         trial = {rem_ff[k], q_ff[k][NB-1]} - {{(NB+1-CW){1'b0}}, d_ff[k]};
         if (!trial[NB]) begin
            rem_in[k] = trial[NB-1:0];
            q_in[k]   = {q_ff[k][NB-2:0], 1'b1};
         end else begin
            rem_in[k] = {rem_ff[k][NB-2:0], q_ff[k][NB-1]};
            q_in[k]   = {q_ff[k][NB-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= '0;
         q_ff[0]   <= {num_mag, {FB{1'b0}}};
         d_ff[0]   <= den_mag;
         for (int k = 0; k < NB; k++) begin
            rem_ff[k+1] <= rem_in[k];
            q_ff[k+1]   <= q_in[k];
            d_ff[k+1]   <= d_ff[k];
         end
      end
   end

   // Saturate the magnitude to CW+1 bits; the caller clamps further by sign.
   assign quo = (|q_ff[NB][NB-1:CW+1]) ? {(CW+1){1'b1}} : q_ff[NB][CW:0];
endmodule

// ===== hdl/ray_box_slab_test_top.sv =====
// Ray versus axis-aligned box slab test, fully pipelined.
// The difference register loads at the accepting edge; CW + FRAC_BITS + 2
// divider registers (each but the first deciding one quotient bit), an ordering
// register and the output register follow.
// Throughput: one transaction per cycle unless stalled; the pipe advances
// whenever the output register is empty or being drained, so a stall freezes
// every stage. Reset clears only the valid bits; data registers are not reset.
module ray_box_slab_test_top
   import rbst_pkg::*;
#(
   parameter int FRAC_BITS   = 16
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);
   localparam int W  = CW;
   localparam int NB = W + 1 + FRAC_BITS;
   localparam int LAT = NB + 4;
   localparam logic signed [W-1:0] T_MIN = {1'b1, {(W-1){1'b0}}};
   localparam logic signed [W-1:0] T_MAX = {1'b0, {(W-1){1'b1}}};

   // The whole pipe moves as one; the output register is the last stage.
   logic adv;
   assign adv = !rsp_valid || rsp_ready;
   assign req_ready = adv;

   logic [LAT-1:0] vld_ff;
   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else if (adv) vld_ff <= {vld_ff[LAT-2:0], req_valid};
   end

   // Stage 1: differences, magnitudes and signs for the six divisions.
   logic signed [W-1:0] o_a [3], d_a [3], lo_a [3], hi_a [3];
   assign o_a  = '{req_data.origin_x[W-1:0], req_data.origin_y[W-1:0],
                   req_data.origin_z[W-1:0]};
   assign d_a  = '{req_data.dir_x[W-1:0], req_data.dir_y[W-1:0],
                   req_data.dir_z[W-1:0]};
   assign lo_a = '{req_data.box_min_x[W-1:0], req_data.box_min_y[W-1:0],
                   req_data.box_min_z[W-1:0]};
   assign hi_a = '{req_data.box_max_x[W-1:0], req_data.box_max_y[W-1:0],
                   req_data.box_max_z[W-1:0]};

   logic [W:0]   nm_ff [6];
   logic [W-1:0] dm_ff [6];
   logic [5:0]   ng_ff, nz_ff;
   logic [2:0]   par_ff, out_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int a = 0; a < 3; a++) begin
            logic signed [W:0] dl, dh;
            logic [W-1:0] dmag;
            dl = {o_a[a][W-1], o_a[a]};
            dl = {lo_a[a][W-1], lo_a[a]} - dl;
            dh = {hi_a[a][W-1], hi_a[a]} - {o_a[a][W-1], o_a[a]};
            dmag = d_a[a][W-1] ? W'(-d_a[a]) : d_a[a];
            nm_ff[2*a]   <= dl[W] ? (W+1)'(-dl) : dl;
            nm_ff[2*a+1] <= dh[W] ? (W+1)'(-dh) : dh;
            dm_ff[2*a] <= dmag;
            dm_ff[2*a+1] <= dmag;
            ng_ff[2*a]   <= dl[W] ^ d_a[a][W-1];
            ng_ff[2*a+1] <= dh[W] ^ d_a[a][W-1];
            nz_ff[2*a]   <= |dl;
            nz_ff[2*a+1] <= |dh;
            par_ff[a] <= d_a[a] == '0;
            out_ff[a] <= (o_a[a] < lo_a[a]) || (o_a[a] > hi_a[a]);
         end
      end
   end

   // Side-band delay alongside the dividers, one entry per divider register.
   logic [5:0] ngd_ff [NB+1], nzd_ff [NB+1];
   logic [2:0] pard_ff [NB+1], outd_ff [NB+1];
   always_ff @(posedge clock) begin
      if (adv) begin
         ngd_ff[0] <= ng_ff; nzd_ff[0] <= nz_ff;
         pard_ff[0] <= par_ff; outd_ff[0] <= out_ff;
         for (int k = 1; k < NB + 1; k++) begin
            ngd_ff[k] <= ngd_ff[k-1]; nzd_ff[k] <= nzd_ff[k-1];
            pard_ff[k] <= pard_ff[k-1]; outd_ff[k] <= outd_ff[k-1];
         end
      end
   end

   logic [W:0] q [6];
   for (genvar i = 0; i < 6; i++) begin : g_div
      rbst_div #(.CW(W), .FB(FRAC_BITS)) u_div (
         .clock(clock), .en(adv), .num_mag(nm_ff[i]),
         .den_mag(dm_ff[i]), .quo(q[i]));
   end

   // Ordering stage: sign and saturate each quotient, then order the two slab
   // parameters of every axis. The integer-part overflow test of the slab
   // division is subsumed by saturating the full quotient. A parallel axis
   // hands on the start interval, so it leaves the narrowing unchanged.
   logic signed [W-1:0] t_s [6];
   logic signed [W-1:0] tn_in [3], tf_in [3];
   logic ins_in;
   always_comb begin
      for (int i = 0; i < 6; i++) begin
         if (!nzd_ff[NB][i]) t_s[i] = '0;
         else if (ngd_ff[NB][i])
            t_s[i] = q[i][W] || (q[i][W-1] && |q[i][W-2:0]) ?
                     T_MIN : W'(-q[i][W-1:0]);
         else
            t_s[i] = (q[i][W] || q[i][W-1]) ? T_MAX : q[i][W-1:0];
      end
      ins_in = 1'b1;
      for (int a = 0; a < 3; a++) begin
         if (pard_ff[NB][a]) begin
            tn_in[a] = T_MIN;
            tf_in[a] = T_MAX;
            if (outd_ff[NB][a]) ins_in = 1'b0;
         end else begin
            tn_in[a] = (t_s[2*a] < t_s[2*a+1]) ? t_s[2*a] : t_s[2*a+1];
            tf_in[a] = (t_s[2*a] < t_s[2*a+1]) ? t_s[2*a+1] : t_s[2*a];
         end
      end
   end

   logic signed [W-1:0] tn_ff [3], tf_ff [3];
   logic ins_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         tn_ff  <= tn_in;
         tf_ff  <= tf_in;
         ins_ff <= ins_in;
      end
   end

   // Final stage: the entry is the latest axis entry and the exit the earliest
   // axis exit; the ray hits when that interval is non-empty and ins_ff is set.
   logic signed [W-1:0] ten, tex;
   logic hit;
   always_comb begin
      ten = tn_ff[0];
      tex = tf_ff[0];
      for (int a = 1; a < 3; a++) begin
         if (tn_ff[a] > ten) ten = tn_ff[a];
         if (tf_ff[a] < tex) tex = tf_ff[a];
      end
      hit = ins_ff && (tex >= ten);
   end

   rsp_type rsp_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_ff.hit     <= hit;
         rsp_ff.t_enter <= CW'(ten);
         rsp_ff.t_exit  <= CW'(tex);
      end
   end
   assign rsp_data  = rsp_ff;
   assign rsp_valid = vld_ff[LAT-1];
endmodule

// ===== hdl/rbst_checker.sv =====
// Port-level checker for the slab test top level, with its bind.
// Depends on rbst_pkg and assert_macros.svh.
`include "assert_macros.svh"
module rbst_checker
   import rbst_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_ready,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data))
   `ASSERT_IMPL(a_ready_free, clock, reset, !rsp_valid, req_ready)
   `ASSERT_IMPL(a_ready_stall, clock, reset, rsp_valid && !rsp_ready, !req_ready)
   `ASSERT_IMPL(a_hit_order, clock, reset, rsp_valid && rsp_data.hit,
                rsp_data.t_exit >= rsp_data.t_enter)
endmodule

bind ray_box_slab_test_top rbst_checker u_rbst_checker (
   .clock(clock), .reset(reset), .req_ready(req_ready),
   .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data));
